// File: sv/bfvi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfvi_pkg: shared types and constants for the Bloom filter vector insert
// Filter geometry, hash constants, probe queue sizing and the job record
// passed from the hash front end to the probe back end.
// ----------------------------------------------------------------------------
package bfvi_pkg;

  // Filter store: 2^FILTER_AW bits, kept as rows of ROW_W bits
  localparam int unsigned FILTER_AW   = 20;
  localparam int unsigned FILTER_BITS = 1 << FILTER_AW;
  localparam int unsigned ROW_W       = 32;
  localparam int unsigned BIT_AW      = $clog2(ROW_W);
  localparam int unsigned ROWS        = FILTER_BITS / ROW_W;
  localparam int unsigned ROW_AW      = $clog2(ROWS);

  // Hashes and counters
  localparam int unsigned HASH_W     = 32;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned SDBM_SH_LO = 6;
  localparam int unsigned SDBM_SH_HI = 16;
  localparam logic [HASH_W-1:0] MX_PRIME = 32'h811C9DC5;

  // Probe count register
  localparam int unsigned HC_W = 5;
  localparam logic [HC_W-1:0] HC_RESET = HC_W'(2);

  // Job queue between front and back
  localparam int unsigned JQ_DEPTH = 2;
  localparam int unsigned JQ_PW    = $clog2(JQ_DEPTH);
  localparam int unsigned JQ_CW    = $clog2(JQ_DEPTH + 1);

  typedef logic [FILTER_AW-1:0] fpos_t;

  // Reduced hashes of one finished vector
  typedef struct packed {
    fpos_t p0;
    fpos_t p1;
  } job_t;

endpackage
`default_nettype wire

// File: sv/bfvi_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfvi_front: element intake and running hashes
// Folds each element into the SDBM and multiply-xor hashes; on the last
// element of a vector it hands the reduced hashes to the job queue.
// ----------------------------------------------------------------------------
module bfvi_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  logic [31:0]    element_value_i,
  input  logic           is_last_i,
  input  logic           stall_i,
  output logic           full_o,
  output logic           job_push_o,
  output bfvi_pkg::job_t job_o
);
  import bfvi_pkg::*;

  logic [HASH_W-1:0] sdbm_q, sdbm_d;
  logic [HASH_W-1:0] mx_q, mx_d, mx_prod;
  logic              accept;

  assign full_o = stall_i;
  assign accept = push_i & ~stall_i;

  // next hash values, wrapping at 32 bits
  assign sdbm_d  = element_value_i + (sdbm_q << SDBM_SH_LO) + (sdbm_q << SDBM_SH_HI) - sdbm_q;
  assign mx_prod = mx_q * MX_PRIME;
  assign mx_d    = mx_prod ^ element_value_i;

  // accumulators restart after the last element
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sdbm_q <= '0;
      mx_q   <= '0;
    end else if (accept) begin
      if (is_last_i) begin
        sdbm_q <= '0;
        mx_q   <= '0;
      end else begin
        sdbm_q <= sdbm_d;
        mx_q   <= mx_d;
      end
    end
  end

  // filter size is a power of two: reduction keeps the low bits
  assign job_push_o = accept & is_last_i;
  assign job_o.p0   = sdbm_d[FILTER_AW-1:0];
  assign job_o.p1   = mx_d[FILTER_AW-1:0];

endmodule
`default_nettype wire

// File: sv/bfvi_job_q.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfvi_job_q: short queue of finished vectors
// Decouples the hash front end from the probe back end.
// ----------------------------------------------------------------------------
module bfvi_job_q (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bfvi_pkg::job_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output bfvi_pkg::job_t data_o
);
  import bfvi_pkg::*;

  job_t             slot_q [JQ_DEPTH];
  logic [JQ_PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [JQ_CW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == JQ_CW'(JQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = slot_q[rd_ptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_ptr_q] <= data_i;
  end

endmodule
`default_nettype wire

// File: sv/bfvi_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfvi_back: probe sequencer and filter store
// Clears the filter after reset, then per job reads every probed bit, sets
// them all if any was clear, keeps the stored count and holds the result.
// ----------------------------------------------------------------------------
module bfvi_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bfvi_pkg::HC_W-1:0]   cfg_wdata_i,
  input  logic                        job_empty_i,
  input  bfvi_pkg::job_t              job_i,
  output logic                        job_pop_o,
  output logic                        clearing_o,
  input  logic                        pop_i,
  output logic                        empty_o,
  output logic                        already_seen_o,
  output logic [bfvi_pkg::CNT_W-1:0]  stored_count_o
);
  import bfvi_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_CHECK = 3'd2;
  localparam logic [2:0] ST_SET   = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [ROW_AW-1:0] clr_row_q, clr_row_d;
  logic [HC_W-1:0]   hc_q;
  logic [HC_W-1:0]   n_q, n_d;
  logic [HC_W-1:0]   idx_q, idx_d;
  fpos_t             p0_q, p0_d, p1_q, p1_d, acc_q, acc_d;
  logic              fresh_q, fresh_d;
  logic              rd_vld_q;
  logic [BIT_AW-1:0] rd_sel_q;
  logic [ROW_W-1:0]  rd_row_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d, cnt_inc;
  logic              res_vld_q, res_vld_d;
  logic              res_seen_q, res_seen_d;
  logic [CNT_W-1:0]  res_cnt_q, res_cnt_d;

  logic [ROW_W-1:0]  mem [ROWS];

  fpos_t             pos;
  logic              more, fresh_now, rd_issue, set_we, clr_we, res_free, res_load;

  // probe position: p0, then p1, then p0 + i*p1 kept as a running sum
  always_comb begin
    if (idx_q == '0) begin
      pos = p0_q;
    end else if (idx_q == HC_W'(1)) begin
      pos = p1_q;
    end else begin
      pos = acc_q;
    end
  end

  assign more      = (idx_q != n_q);
  assign fresh_now = fresh_q | (rd_vld_q & ~rd_row_q[rd_sel_q]);
  assign rd_issue  = (state_q == ST_CHECK) & more;
  assign set_we    = (state_q == ST_SET) & more;
  assign clr_we    = (state_q == ST_CLEAR);
  assign res_free  = ~res_vld_q | pop_i;
  assign res_load  = (state_q == ST_DONE) & res_free;
  assign cnt_inc   = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;

  // sequencer
  always_comb begin
    state_d   = state_q;
    clr_row_d = clr_row_q;
    n_d       = n_q;
    idx_d     = idx_q;
    p0_d      = p0_q;
    p1_d      = p1_q;
    acc_d     = acc_q;
    fresh_d   = fresh_q;
    cnt_d     = cnt_q;
    job_pop_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        clr_row_d = clr_row_q + 1'b1;
        if (clr_row_q == '1) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (!job_empty_i) begin
          job_pop_o = 1'b1;
          p0_d      = job_i.p0;
          p1_d      = job_i.p1;
          acc_d     = job_i.p0;
          idx_d     = '0;
          fresh_d   = 1'b0;
          n_d       = hc_q;
          state_d   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        fresh_d = fresh_now;
        if (more) begin
          idx_d = idx_q + 1'b1;
          acc_d = acc_q + p1_q;
        end else if (fresh_now) begin
          idx_d   = '0;
          acc_d   = p0_q;
          state_d = ST_SET;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_SET: begin
        if (more) begin
          idx_d = idx_q + 1'b1;
          acc_d = acc_q + p1_q;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_free) begin
          if (fresh_q) cnt_d = cnt_inc;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // result register
  always_comb begin
    res_vld_d  = res_vld_q & ~pop_i;
    res_seen_d = res_seen_q;
    res_cnt_d  = res_cnt_q;
    if (res_load) begin
      res_vld_d  = 1'b1;
      res_seen_d = ~fresh_q;
      res_cnt_d  = fresh_q ? cnt_inc : cnt_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_row_q <= '0;
      hc_q      <= HC_RESET;
      n_q       <= '0;
      idx_q     <= '0;
      fresh_q   <= 1'b0;
      rd_vld_q  <= 1'b0;
      cnt_q     <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_row_q <= clr_row_d;
      if (cfg_we_i) hc_q <= cfg_wdata_i;
      n_q       <= n_d;
      idx_q     <= idx_d;
      fresh_q   <= fresh_d;
      rd_vld_q  <= rd_issue;
      cnt_q     <= cnt_d;
      res_vld_q <= res_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    p0_q       <= p0_d;
    p1_q       <= p1_d;
    acc_q      <= acc_d;
    rd_sel_q   <= pos[BIT_AW-1:0];
    res_seen_q <= res_seen_d;
    res_cnt_q  <= res_cnt_d;
  end

  // filter store: row clear, single bit set, registered row read
  always_ff @(posedge clk_i) begin
    if (clr_we) begin
      mem[clr_row_q] <= '0;
    end else if (set_we) begin
      mem[pos[FILTER_AW-1:BIT_AW]][pos[BIT_AW-1:0]] <= 1'b1;
    end
    rd_row_q <= mem[pos[FILTER_AW-1:BIT_AW]];
  end

  assign clearing_o     = (state_q == ST_CLEAR);
  assign empty_o        = ~res_vld_q;
  assign already_seen_o = res_seen_q;
  assign stored_count_o = res_cnt_q;

endmodule
`default_nettype wire

// File: sv/bloom_filter_vector_insert.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bloom_filter_vector_insert: Bloom filter insert for streamed vectors
// Hashes each vector as it streams in and probes/sets a 1 Mbit filter with
// double hashing, reporting per vector whether it was already present.
// ----------------------------------------------------------------------------
//  channel   | handshake          | payload
//  ----------+--------------------+----------------------------------------
//  input     | push / full        | element_value_i[31:0], is_last_i
//  result    | empty / pop        | already_seen_o, stored_count_o[31:0]
//  config    | cfg_we_i           | cfg_wdata_i[4:0] (probes per vector)
//
//  Elements are taken one per cycle while full is low; one result follows
//  each last element. For n probes the probe unit runs a check pass and,
//  only for new vectors, a set pass, one filter access per cycle.
//  After reset the filter is cleared one row a cycle, 32768 rows in all;
//  full stays high meanwhile. Up to two finished vectors wait in a queue,
//  so after clearing the input only stalls when that queue is full.
// ----------------------------------------------------------------------------
module bloom_filter_vector_insert (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [31:0] element_value_i,
  input  logic        is_last_i,
  input  logic        pop,
  output logic        empty,
  output logic        already_seen_o,
  output logic [31:0] stored_count_o,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i
);
  import bfvi_pkg::*;

  logic job_push, job_full, job_pop, job_empty, clearing;
  job_t job_in, job_out;

  // hash front end
  bfvi_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .element_value_i (element_value_i),
    .is_last_i       (is_last_i),
    .stall_i         (job_full | clearing),
    .full_o          (full),
    .job_push_o      (job_push),
    .job_o           (job_in)
  );

  // queue of finished vectors
  bfvi_job_q u_job_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .empty_o (job_empty),
    .data_o  (job_out)
  );

  // probe back end with filter store
  bfvi_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .job_empty_i    (job_empty),
    .job_i          (job_out),
    .job_pop_o      (job_pop),
    .clearing_o     (clearing),
    .pop_i          (pop),
    .empty_o        (empty),
    .already_seen_o (already_seen_o),
    .stored_count_o (stored_count_o)
  );

endmodule
`default_nettype wire

// File: sv/bfvi_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfvi_checker: port level checks for the Bloom filter vector insert
// Watches reset behaviour, result hold and stored count consistency.
// ----------------------------------------------------------------------------
module bfvi_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic        already_seen_o,
  input logic [31:0] stored_count_o
);

  // straight out of reset the filter is being cleared and nothing is waiting
  a_reset_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> (full && empty))
    else $error("input open or result shown straight after reset");

  // a waiting result stays until popped
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(already_seen_o) && $stable(stored_count_o)))
    else $error("waiting result changed or vanished");

  // a newly stored vector means the count is at least one
  a_new_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !already_seen_o) |-> (stored_count_o != 32'd0))
    else $error("new vector reported with zero stored count");

  // a seen vector leaves the count as the previous result showed it
  a_seen_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop) ##1 (!empty && already_seen_o) |-> (stored_count_o == $past(stored_count_o)))
    else $error("stored count moved on a seen vector");

endmodule

bind bloom_filter_vector_insert bfvi_checker u_bfvi_checker (.*);
`default_nettype wire

// File: sim/bloom_filter_vector_insert_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bloom_filter_vector_insert_checker: result predictor and comparator
// Watches the element, result and probe-count channels of the Bloom filter
// insert block. Every accepted element is folded into its own pair of running
// hashes. On a last element the probes against its own copy of the filter are
// worked out and the expected result is queued. Each result taken from the
// block is compared field by field with the oldest expectation.
// ----------------------------------------------------------------------------
module bloom_filter_vector_insert_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  logic        full,
  input  logic [31:0] element_value_i,
  input  logic        is_last_i,
  input  logic        pop,
  input  logic        empty,
  input  logic        already_seen_o,
  input  logic [31:0] stored_count_o,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  output int          fail_count,
  output int          owed
);
  import bfvi_pkg::*;

  localparam int MAX_PROBES = 1 << HC_W;

  typedef struct packed {
    logic             already_seen;
    logic [CNT_W-1:0] stored_count;
  } insert_result_t;

  // Filter mirror: bit variables start at zero, as the store does after its
  // clearing pass, and reset is only ever applied once at the start
  bit                filter_mirror [FILTER_BITS];
  logic [HASH_W-1:0] sdbm_h;
  logic [HASH_W-1:0] mx_h;
  logic [CNT_W-1:0]  vectors_stored;
  logic [HC_W-1:0]   probes;
  insert_result_t    result_q [$];

  // Fold one element into both hashes; on the last one probe and insert
  task automatic absorb_element(input logic [HASH_W-1:0] e, input logic last);
    fpos_t          pos [MAX_PROBES];
    logic [63:0]    p0;
    logic [63:0]    p1;
    logic [63:0]    p;
    logic           fresh;
    insert_result_t r;
    int             i;
    sdbm_h = e + (sdbm_h << SDBM_SH_LO) + (sdbm_h << SDBM_SH_HI) - sdbm_h;
    mx_h   = (mx_h * MX_PRIME) ^ e;
    if (!last) return;
    p0     = 64'(sdbm_h) % 64'(FILTER_BITS);
    p1     = 64'(mx_h) % 64'(FILTER_BITS);
    sdbm_h = '0;
    mx_h   = '0;
    fresh  = 1'b0;
    // exact double hashing, no 32-bit wrap of i*p1
    for (i = 0; i < int'(probes); i++) begin
      if (i == 0) p = p0;
      else if (i == 1) p = p1;
      else p = (p0 + 64'(i) * p1) % 64'(FILTER_BITS);
      pos[i] = fpos_t'(p);
      if (!filter_mirror[pos[i]]) fresh = 1'b1;
    end
    // set pass only for a vector not yet present
    if (fresh) begin
      for (i = 0; i < int'(probes); i++) filter_mirror[pos[i]] = 1'b1;
      if (vectors_stored != '1) vectors_stored++;
    end
    r.already_seen = !fresh;
    r.stored_count = vectors_stored;
    result_q.push_back(r);
  endtask

  // Compare one result transaction with the oldest expectation
  task automatic check_result();
    insert_result_t want;
    if (result_q.size() == 0) begin
      $error("result with none expected: already_seen %0b stored_count %0d",
             already_seen_o, stored_count_o);
      fail_count++;
      return;
    end
    want = result_q.pop_front();
    if (already_seen_o !== want.already_seen) begin
      $error("already_seen: expected %0b, got %0b", want.already_seen, already_seen_o);
      fail_count++;
    end
    if (stored_count_o !== want.stored_count) begin
      $error("stored_count: expected %0d, got %0d", want.stored_count, stored_count_o);
      fail_count++;
    end
  endtask

  // Sample all channels at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sdbm_h         = '0;
      mx_h           = '0;
      vectors_stored = '0;
      probes         = HC_RESET;
      fail_count     = 0;
      result_q.delete();
      owed <= 0;
    end else begin
      if (cfg_we_i) probes = cfg_wdata_i;
      if (pop && !empty) check_result();
      if (push && !full) absorb_element(element_value_i, is_last_i);
      owed <= result_q.size();
    end
  end

endmodule

// File: sim/bloom_filter_vector_insert_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bloom_filter_vector_insert_tb: testbench top for the Bloom filter insert
// Streams directed and random vectors through the block under a range of
// probe counts (zero, one and the maximum among them), replaying earlier
// vectors so that both new and already-present outcomes occur. Both sides
// idle at random; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module bloom_filter_vector_insert_tb;
  import bfvi_pkg::*;

  localparam int WATCHDOG_LIMIT = 100000;  // exceeds the clearing pass
  localparam int PROBE_SETTLE   = 100;     // covers the longest probe/set pass
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 244;

  logic            clk_i           = 1'b0;
  logic            rst_ni          = 1'b0;
  logic            push            = 1'b0;
  logic            full;
  logic [31:0]     element_value_i = '0;
  logic            is_last_i       = 1'b0;
  logic            pop             = 1'b0;
  logic            empty;
  logic            already_seen_o;
  logic [31:0]     stored_count_o;
  logic            cfg_we_i        = 1'b0;
  logic [HC_W-1:0] cfg_wdata_i     = '0;

  int fail_count;
  int owed;
  int idle_cycles = 0;
  int items_sent  = 0;
  bit steady_in   = 1'b0;

  // result side idling state
  int out_stall_left = 0;
  int out_mode_left  = 0;
  bit steady_out     = 1'b0;

  // every vector sent, flattened, for replay
  logic [31:0] lib_elems [$];
  int          lib_first [$];
  int          lib_len   [$];
  logic [31:0] vec_buf   [$];

  bloom_filter_vector_insert dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .element_value_i (element_value_i),
    .is_last_i       (is_last_i),
    .pop             (pop),
    .empty           (empty),
    .already_seen_o  (already_seen_o),
    .stored_count_o  (stored_count_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  bloom_filter_vector_insert_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .element_value_i (element_value_i),
    .is_last_i       (is_last_i),
    .pop             (pop),
    .empty           (empty),
    .already_seen_o  (already_seen_o),
    .stored_count_o  (stored_count_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .fail_count      (fail_count),
    .owed            (owed)
  );

  // 12 ns clock
  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Watchdog: cycles with no transaction on either side
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random stalls, mostly short, some long, with steady stretches
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (out_mode_left == 0) begin
        steady_out    = ($urandom_range(0, 3) == 0);
        out_mode_left = $urandom_range(50, 300);
      end else begin
        out_mode_left--;
      end
      if (out_stall_left > 0) begin
        out_stall_left--;
        pop <= 1'b0;
      end else if (!steady_out && $urandom_range(0, 3) == 0) begin
        out_stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                                     : $urandom_range(0, 2);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (steady_in) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] pick_element();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2, 3:    return $urandom_range(0, 15);
      default: return $urandom();
    endcase
  endfunction

  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 4);
    if (r < 95) return $urandom_range(5, 12);
    return $urandom_range(13, 40);
  endfunction

  // One element transaction, with an optional gap in front
  task automatic send_element(input logic [31:0] value, input logic last);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push            <= 1'b1;
    element_value_i <= value;
    is_last_i       <= last;
    do @(posedge clk_i); while (full);
    items_sent++;
  endtask

  // Send vec_buf as one vector and keep it for replay
  task automatic send_buffered();
    int j;
    lib_first.push_back(lib_elems.size());
    lib_len.push_back(vec_buf.size());
    for (j = 0; j < vec_buf.size(); j++) begin
      lib_elems.push_back(vec_buf[j]);
      send_element(vec_buf[j], j == vec_buf.size() - 1);
    end
  endtask

  task automatic send_replay(input int k);
    int j;
    for (j = 0; j < lib_len[k]; j++)
      send_element(lib_elems[lib_first[k] + j], j == lib_len[k] - 1);
  endtask

  task automatic send_random_vector();
    int n;
    int j;
    n = pick_length();
    vec_buf.delete();
    for (j = 0; j < n; j++) vec_buf.push_back(pick_element());
    send_buffered();
  endtask

  // Hold the input until every expected result has been taken
  task automatic await_drain();
    @(negedge clk_i);
    push <= 1'b0;
    while (owed != 0) @(posedge clk_i);
  endtask

  task automatic set_probe_count(input logic [HC_W-1:0] n);
    await_drain();
    repeat (PROBE_SETTLE) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= n;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic [HC_W-1:0] fixed_counts [5];
    logic [HC_W-1:0] hc;
    int              ph;
    fixed_counts = '{HC_W'(2), HC_W'(0), HC_W'(1), HC_W'(31), HC_W'(16)};

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (ph = 0; ph < PHASES; ph++) begin
      hc = (ph < 5) ? fixed_counts[ph] : HC_W'($urandom_range(0, 31));
      set_probe_count(hc);
      if (ph == 0) begin
        // directed: extreme elements, single and multi element vectors, repeats
        vec_buf = '{32'h0000_0000};
        send_buffered();
        vec_buf = '{32'hFFFF_FFFF};
        send_buffered();
        send_replay(0);
        vec_buf = '{32'h1, 32'h2, 32'h3};
        send_buffered();
        vec_buf = '{32'h8000_0000, 32'h7FFF_FFFF};
        send_buffered();
        vec_buf = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0};
        send_buffered();
        send_replay(2);
        send_replay(1);
      end else begin
        // vectors stored under an earlier probe count
        send_replay(0);
        send_replay(2);
      end
      while (items_sent < (ph + 1) * PHASE_ITEMS) begin
        if ($urandom_range(0, 14) == 0) steady_in = !steady_in;
        if ($urandom_range(0, 99) < 30)
          send_replay($urandom_range(0, lib_len.size() - 1));
        else
          send_random_vector();
        if ($urandom_range(0, 29) == 0) await_drain();
      end
    end

    await_drain();
    repeat (PROBE_SETTLE) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: bloom_filter_vector_insert.f
sv/bfvi_pkg.sv
sv/bfvi_front.sv
sv/bfvi_job_q.sv
sv/bfvi_back.sv
sv/bloom_filter_vector_insert.sv
sv/bfvi_checker.sv
sim/bloom_filter_vector_insert_checker.sv
sim/bloom_filter_vector_insert_tb.sv
